// ===== hw/rtl/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// shared types, constants and helpers of the pressure compensation block
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_AC1_AC2 = 3'd0;
  localparam logic [2:0] REG_AC3_AC4 = 3'd1;
  localparam logic [2:0] REG_AC5_AC6 = 3'd2;
  localparam logic [2:0] REG_B1_B2   = 3'd3;
  localparam logic [2:0] REG_MC_MD   = 3'd4;

  // input modes and result status codes
  localparam logic MODE_TEMP  = 1'b0;
  localparam logic MODE_PRESS = 1'b1;
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_DIVZERO = 1'b1;

  // compensation constants
  localparam logic [31:0] C_B6_OFFSET = 32'd4000;
  localparam logic [31:0] C_X3_BIAS   = 32'd32768;
  localparam logic [31:0] C_B7_SCALE  = 32'd50000;
  localparam logic [31:0] C_P_SQ      = 32'd3038;
  localparam logic [31:0] C_P_LIN     = 32'hFFFF_E343;  // -7357
  localparam logic [31:0] C_P_OFFSET  = 32'd3791;

  // datapath micro steps
  typedef enum logic [4:0] {
    ST_NONE, ST_LOAD,
    ST_T0, ST_T1, ST_T2,
    ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8, ST_P9, ST_P9B,
    ST_P10, ST_P11, ST_P12, ST_P13, ST_P14,
    ST_ERR
  } step_e;

  // controller to datapath
  typedef struct packed {
    step_e step;
    logic  div_start;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic den_zero;
    logic b4_zero;
    logic div_done;
  } stat_t;

  // arithmetic right shift of a 32-bit pattern
  function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
    asr = $unsigned($signed(v) >>> s);
  endfunction

  // sign extension of a 16-bit coefficient
  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bpc_if.sv =====
// ----------------------------------------------------------------------------
// bpc_if
// valid/ready channels of the pressure compensation block
// ----------------------------------------------------------------------------
`default_nettype none

interface bpc_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [23:0] raw_sample;
  logic [1:0]  oversampling;
  modport source (output valid, output mode, output raw_sample, output oversampling,
                  input ready);
  modport sink (input valid, input mode, input raw_sample, input oversampling,
                output ready);
endinterface

interface bpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic               status;
  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

interface bpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/barometric_pressure_compensation.sv =====
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// integer temperature and pressure compensation of raw barometer conversions
// ----------------------------------------------------------------------------
// temperature and pressure items run as step sequences through the bit-serial divider
// and the single shared multiplier, from accept to result
// throughput: one item at a time, next item taken as soon as the sequencer is idle
// a finished result waits in the output register while the next item runs
// reset: asynchronous active low, clears calibration registers and the kept intermediate
`default_nettype none

module barometric_pressure_compensation
  import bpc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bpc_cfg_if.sink   cfg_if,
  bpc_in_if.sink    in_if,
  bpc_out_if.source out_if
);

  cmd_t  cmd;
  stat_t stat;
  logic [31:0] value;

  bpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_mode_i   (in_if.mode),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bpc_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_we_i       (cfg_if.valid),
    .cfg_index_i    (cfg_if.index),
    .cfg_data_i     (cfg_if.data),
    .raw_sample_i   (in_if.raw_sample),
    .oversampling_i (in_if.oversampling),
    .value_o        (value),
    .status_o       (out_if.status)
  );

  // configuration writes always taken
  assign cfg_if.ready = 1'b1;
  assign out_if.value = $signed(value);

endmodule

`default_nettype wire

// ===== hw/rtl/bpc_divider.sv =====
// ----------------------------------------------------------------------------
// bpc_divider
// unsigned 32 by 32 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] num_i,
  input  wire logic [31:0] den_i,
  output logic             done_o,
  output logic [31:0]      quo_o
);

  logic [31:0] rem_q, rem_d, quo_q, quo_d, den_q;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] rem_sh, diff;

  // one restoring step
  always_comb begin
    rem_sh = {rem_q, quo_q[31]};
    diff   = rem_sh - {1'b0, den_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_d = diff[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = rem_sh[31:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operands
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bpc_datapath.sv =====
// ----------------------------------------------------------------------------
// bpc_datapath
// calibration registers, working registers, shared multiplier and divider
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_datapath
  import bpc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  output stat_t            stat_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic [23:0] raw_sample_i,
  input  wire logic [1:0]  oversampling_i,
  output logic [31:0]      value_o,
  output logic             status_o
);

  logic [31:0] cal0_q, cal1_q, cal2_q, cal3_q, cal4_q, ti_q;
  logic [23:0] raw_q;
  logic [1:0]  oss_q;
  logic [31:0] acc_q, aux_q, b6_q, sq_q, b3_q, b4_q, p_q, value_q;
  logic        neg_q, wide_q, status_q;

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  logic [31:0] ut, up, scale, den, num_t;
  logic [31:0] mul_a, mul_b, prod;
  logic [31:0] div_n, div_d, div_q, x2, b5, p8;
  logic        div_done;

  // coefficient fields
  assign ac1 = sx16(cal0_q[31:16]);
  assign ac2 = sx16(cal0_q[15:0]);
  assign ac3 = sx16(cal1_q[31:16]);
  assign ac4 = {16'd0, cal1_q[15:0]};
  assign ac5 = {16'd0, cal2_q[31:16]};
  assign ac6 = {16'd0, cal2_q[15:0]};
  assign b1  = sx16(cal3_q[31:16]);
  assign b2  = sx16(cal3_q[15:0]);
  assign mc  = sx16(cal4_q[31:16]);
  assign md  = sx16(cal4_q[15:0]);

  // raw values and derived terms
  assign ut    = {16'd0, raw_q[15:0]};
  assign up    = {8'd0, raw_q} >> (4'd8 - {2'd0, oss_q});
  assign scale = C_B7_SCALE >> oss_q;
  assign den   = acc_q + md;
  assign num_t = mc << 11;
  assign p8    = asr(p_q, 5'd8);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.step)
      ST_T0:   begin mul_a = ut - ac6;  mul_b = ac5;       end
      ST_P1:   begin mul_a = b6_q;      mul_b = b6_q;      end
      ST_P2:   begin mul_a = b2;        mul_b = sq_q;      end
      ST_P3:   begin mul_a = ac2;       mul_b = b6_q;      end
      ST_P5:   begin mul_a = ac3;       mul_b = b6_q;      end
      ST_P6:   begin mul_a = b1;        mul_b = sq_q;      end
      ST_P8:   begin mul_a = ac4;       mul_b = acc_q;     end
      ST_P9:   begin mul_a = up - b3_q; mul_b = scale;     end
      ST_P11:  begin mul_a = p8;        mul_b = p8;        end
      ST_P12:  begin mul_a = acc_q;     mul_b = C_P_SQ;    end
      ST_P13:  begin mul_a = C_P_LIN;   mul_b = p_q;       end
      default: begin mul_a = '0;        mul_b = '0;        end
    endcase
  end

  assign prod = mul_a * mul_b;

  // divider operand select
  always_comb begin
    if (cmd_i.step == ST_P9B) begin
      div_n = p_q[31] ? p_q : (p_q << 1);
      div_d = b4_q;
    end else begin
      div_n = num_t[31] ? (32'd0 - num_t) : num_t;
      div_d = den[31] ? (32'd0 - den) : den;
    end
  end

  bpc_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_n),
    .den_i   (div_d),
    .done_o  (div_done),
    .quo_o   (div_q)
  );

  assign x2 = neg_q ? (32'd0 - div_q) : div_q;
  assign b5 = acc_q + x2;

  // calibration registers and kept intermediate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal0_q <= '0;
      cal1_q <= '0;
      cal2_q <= '0;
      cal3_q <= '0;
      cal4_q <= '0;
      ti_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_AC1_AC2: cal0_q <= cfg_data_i;
          REG_AC3_AC4: cal1_q <= cfg_data_i;
          REG_AC5_AC6: cal2_q <= cfg_data_i;
          REG_B1_B2:   cal3_q <= cfg_data_i;
          REG_MC_MD:   cal4_q <= cfg_data_i;
          default:     ;
        endcase
      end
      if (cmd_i.step == ST_T2) ti_q <= b5;
    end
  end

  // working registers, one step per cycle while the controller issues steps
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.step)
      ST_LOAD: begin raw_q <= raw_sample_i; oss_q <= oversampling_i; end
      ST_T0:   acc_q <= asr(prod, 5'd15);
      ST_T1:   neg_q <= num_t[31] ^ den[31];
      ST_T2: begin
        value_q  <= asr(b5 + 32'd8, 5'd4);
        status_q <= STATUS_OK;
      end
      ST_P0:   b6_q  <= ti_q - C_B6_OFFSET;
      ST_P1:   sq_q  <= asr(prod, 5'd12);
      ST_P2:   acc_q <= asr(prod, 5'd11);
      ST_P3:   acc_q <= acc_q + asr(prod, 5'd11);
      ST_P4:   b3_q  <= asr((((ac1 << 2) + acc_q) << oss_q) + 32'd2, 5'd2);
      ST_P5:   acc_q <= asr(prod, 5'd13);
      ST_P6:   acc_q <= acc_q + asr(prod, 5'd16);
      ST_P7:   acc_q <= asr(acc_q + 32'd2, 5'd2) + C_X3_BIAS;
      ST_P8:   b4_q  <= prod >> 15;
      ST_P9:   p_q   <= prod;
      ST_P9B:  wide_q <= p_q[31];
      ST_P10:  p_q   <= wide_q ? (div_q << 1) : div_q;
      ST_P11:  acc_q <= prod;
      ST_P12:  acc_q <= asr(prod, 5'd16);
      ST_P13:  aux_q <= asr(prod, 5'd16);
      ST_P14: begin
        value_q  <= p_q + asr(acc_q + aux_q + C_P_OFFSET, 5'd4);
        status_q <= STATUS_OK;
      end
      ST_ERR: begin
        value_q  <= '0;
        status_q <= STATUS_DIVZERO;
      end
      default: ;
    endcase
  end

  assign stat_o.den_zero = (den == 32'd0);
  assign stat_o.b4_zero  = (b4_q == 32'd0);
  assign stat_o.div_done = div_done;
  assign value_o  = value_q;
  assign status_o = status_q;

endmodule

`default_nettype wire

// ===== hw/rtl/bpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpc_ctrl
// sequencer of the temperature and pressure step lists and the output slot
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_ctrl
  import bpc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  input  wire logic  in_mode_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_T0   = 5'd1;
  localparam logic [4:0] S_T1   = 5'd2;
  localparam logic [4:0] S_TDIV = 5'd3;
  localparam logic [4:0] S_T2   = 5'd4;
  localparam logic [4:0] S_P0   = 5'd5;
  localparam logic [4:0] S_P1   = 5'd6;
  localparam logic [4:0] S_P2   = 5'd7;
  localparam logic [4:0] S_P3   = 5'd8;
  localparam logic [4:0] S_P4   = 5'd9;
  localparam logic [4:0] S_P5   = 5'd10;
  localparam logic [4:0] S_P6   = 5'd11;
  localparam logic [4:0] S_P7   = 5'd12;
  localparam logic [4:0] S_P8   = 5'd13;
  localparam logic [4:0] S_P9   = 5'd14;
  localparam logic [4:0] S_P9B  = 5'd15;
  localparam logic [4:0] S_PDIV = 5'd16;
  localparam logic [4:0] S_P10  = 5'd17;
  localparam logic [4:0] S_P11  = 5'd18;
  localparam logic [4:0] S_P12  = 5'd19;
  localparam logic [4:0] S_P13  = 5'd20;
  localparam logic [4:0] S_P14  = 5'd21;
  localparam logic [4:0] S_ERR  = 5'd22;

  logic [4:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free, accept, wr;

  assign slot_free = !out_valid_q || out_ready_i;
  assign accept    = in_valid_i && (state_q == S_IDLE);

  // next state and step command
  always_comb begin
    state_d       = state_q;
    cmd_o.step    = ST_NONE;
    cmd_o.div_start = 1'b0;
    wr            = 1'b0;
    unique case (state_q)
      S_IDLE: if (accept) begin
        cmd_o.step = ST_LOAD;
        state_d    = (in_mode_i == MODE_TEMP) ? S_T0 : S_P0;
      end
      S_T0: begin cmd_o.step = ST_T0; state_d = S_T1; end
      S_T1: begin
        cmd_o.step = ST_T1;
        if (stat_i.den_zero) begin
          state_d = S_ERR;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = S_TDIV;
        end
      end
      S_TDIV: if (stat_i.div_done) state_d = S_T2;
      S_T2: if (slot_free) begin
        cmd_o.step = ST_T2; wr = 1'b1; state_d = S_IDLE;
      end
      S_P0: begin cmd_o.step = ST_P0; state_d = S_P1; end
      S_P1: begin cmd_o.step = ST_P1; state_d = S_P2; end
      S_P2: begin cmd_o.step = ST_P2; state_d = S_P3; end
      S_P3: begin cmd_o.step = ST_P3; state_d = S_P4; end
      S_P4: begin cmd_o.step = ST_P4; state_d = S_P5; end
      S_P5: begin cmd_o.step = ST_P5; state_d = S_P6; end
      S_P6: begin cmd_o.step = ST_P6; state_d = S_P7; end
      S_P7: begin cmd_o.step = ST_P7; state_d = S_P8; end
      S_P8: begin cmd_o.step = ST_P8; state_d = S_P9; end
      S_P9: begin cmd_o.step = ST_P9; state_d = S_P9B; end
      S_P9B: begin
        cmd_o.step = ST_P9B;
        if (stat_i.b4_zero) begin
          state_d = S_ERR;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d = S_PDIV;
        end
      end
      S_PDIV: if (stat_i.div_done) state_d = S_P10;
      S_P10: begin cmd_o.step = ST_P10; state_d = S_P11; end
      S_P11: begin cmd_o.step = ST_P11; state_d = S_P12; end
      S_P12: begin cmd_o.step = ST_P12; state_d = S_P13; end
      S_P13: begin cmd_o.step = ST_P13; state_d = S_P14; end
      S_P14: if (slot_free) begin
        cmd_o.step = ST_P14; wr = 1'b1; state_d = S_IDLE;
      end
      S_ERR: if (slot_free) begin
        cmd_o.step = ST_ERR; wr = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output slot valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (wr) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
